// ===== hw/rtl/wrms_pkg.sv =====
// Shared constants, record and control types for the win-ratio merge sorter.
package wrms_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int COUNT_BITS = 16;
    localparam int FIELD_W    = 16;
    localparam int REC_W      = 3 * FIELD_W;
    localparam int CMP_W      = (COUNT_BITS >= FIELD_W) ? FIELD_W : COUNT_BITS;
    localparam int PROD_W     = 2 * CMP_W + 1;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W      = CNT_W + 2;
    localparam int AW         = $clog2(MAX_ITEMS);

    // tag in the low bits, as on the stream
    typedef struct packed {
        logic [FIELD_W-1:0] losses;
        logic [FIELD_W-1:0] wins;
        logic [FIELD_W-1:0] tag;
    } rec_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PASS,
        ST_BLK,
        ST_MCHK,
        ST_MMUL,
        ST_MWR,
        ST_ECHK,
        ST_ERD,
        ST_ELD,
        ST_EOUT
    } state_t;

    typedef struct packed {
        logic load_rdy;
        logic pass_next;
        logic blk_init;
        logic blk_next;
        logic mul;
        logic step;
        logic em_init;
        logic emit_mode;
        logic em_load;
        logic run_clear;
    } cmd_t;

    typedef struct packed {
        logic last_acc;
        logic pass_more;
        logic blk_more;
        logic mrg_more;
        logic em_more;
        logic out_taken;
    } stat_t;

endpackage

// ===== hw/rtl/wrms_ctrl.sv =====
// Sequencer for load, merge passes and emit of the win-ratio merge sorter.
module wrms_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  wrms_pkg::stat_t stat,
    output wrms_pkg::cmd_t  cmd
);
    import wrms_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: if (stat.last_acc) state_next = ST_PASS;
            ST_PASS: state_next = stat.pass_more ? ST_BLK : ST_ECHK;
            ST_BLK:  state_next = stat.blk_more ? ST_MCHK : ST_PASS;
            ST_MCHK: state_next = stat.mrg_more ? ST_MMUL : ST_BLK;
            ST_MMUL: state_next = ST_MWR;
            ST_MWR:  state_next = ST_MCHK;
            ST_ECHK: state_next = stat.em_more ? ST_ERD : ST_LOAD;
            ST_ERD:  state_next = ST_ELD;
            ST_ELD:  state_next = ST_EOUT;
            ST_EOUT: if (stat.out_taken) state_next = ST_ECHK;
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_LOAD: cmd.load_rdy = 1'b1;
            ST_PASS: cmd.em_init = !stat.pass_more;
            ST_BLK:
            begin
                cmd.blk_init  = stat.blk_more;
                cmd.pass_next = !stat.blk_more;
            end
            ST_MCHK: cmd.blk_next = !stat.mrg_more;
            ST_MMUL: cmd.mul = 1'b1;
            ST_MWR:  cmd.step = 1'b1;
            ST_ECHK:
            begin
                cmd.emit_mode = 1'b1;
                cmd.run_clear = !stat.em_more;
            end
            ST_ERD:  cmd.emit_mode = 1'b1;
            ST_ELD:
            begin
                cmd.emit_mode = 1'b1;
                cmd.em_load   = 1'b1;
            end
            ST_EOUT: cmd.emit_mode = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/wrms_dp.sv =====
// Record banks, merge counters, ratio compare and output register.
module wrms_dp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic [wrms_pkg::REC_W-1:0]  s_tdata,
    input  logic                        s_tlast,
    input  logic                        m_tready,
    input  wrms_pkg::cmd_t              cmd,
    output wrms_pkg::stat_t             stat,
    output logic                        m_tvalid,
    output logic [wrms_pkg::REC_W-1:0]  m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);
    import wrms_pkg::*;

    // two banks, ping-pong between merge passes
    rec_t bank0 [MAX_ITEMS];
    rec_t bank1 [MAX_ITEMS];

    logic [CNT_W-1:0]  count_reg;
    logic              overflow_reg;
    logic [SUM_W-1:0]  width_reg;
    logic [SUM_W-1:0]  lo_reg;
    logic              src_reg;
    logic [CNT_W-1:0]  mid_reg;
    logic [CNT_W-1:0]  hi_reg;
    logic [CNT_W-1:0]  i_reg;
    logic [CNT_W-1:0]  j_reg;
    logic [CNT_W-1:0]  k_reg;
    logic              out_valid_reg;
    rec_t              out_rec_reg;
    logic              out_last_reg;
    logic              out_drop_reg;
    rec_t              rd_a_reg;
    rec_t              rd_b_reg;
    logic [PROD_W-1:0] prod_lhs_reg;
    logic [PROD_W-1:0] prod_rhs_reg;

    logic              acc;
    logic              full;
    rec_t              in_rec;
    logic              wr0_en;
    logic              wr1_en;
    logic [AW-1:0]     wr0_addr;
    rec_t              wr0_data;
    logic [AW-1:0]     addr_a;
    logic [AW-1:0]     addr_b;
    logic [SUM_W-1:0]  count_ext;
    logic [SUM_W-1:0]  mid_sum;
    logic [SUM_W-1:0]  hi_sum;
    logic [CNT_W-1:0]  mid_calc;
    logic [CNT_W-1:0]  hi_calc;
    logic [CMP_W-1:0]  wi;
    logic [CMP_W-1:0]  wj;
    logic [CMP_W:0]    ti;
    logic [CMP_W:0]    tj;
    logic [CMP_W-1:0]  wi_eff;
    logic [CMP_W-1:0]  wj_eff;
    logic [CMP_W:0]    ti_eff;
    logic [CMP_W:0]    tj_eff;
    logic              less;
    logic              take_j;
    rec_t              wr_rec;

    assign acc    = s_tvalid && cmd.load_rdy;
    assign full   = (count_reg == CNT_W'(MAX_ITEMS));
    assign in_rec = rec_t'(s_tdata);

    // --- memories ---
    assign wr0_en   = (acc && !full) || (cmd.step && src_reg);
    assign wr1_en   = cmd.step && !src_reg;
    assign wr0_addr = acc ? count_reg[AW-1:0] : k_reg[AW-1:0];
    assign wr0_data = acc ? in_rec : wr_rec;
    assign addr_a   = cmd.emit_mode ? k_reg[AW-1:0] : i_reg[AW-1:0];
    assign addr_b   = j_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr0_en)
        begin
            bank0[wr0_addr] <= wr0_data;
        end
        if (wr1_en)
        begin
            bank1[k_reg[AW-1:0]] <= wr_rec;
        end
        rd_a_reg <= src_reg ? bank1[addr_a] : bank0[addr_a];
        rd_b_reg <= src_reg ? bank1[addr_b] : bank0[addr_b];
    end

    // --- block bounds ---
    assign count_ext = SUM_W'(count_reg);
    assign mid_sum   = lo_reg + width_reg;
    assign hi_sum    = lo_reg + (width_reg << 1);
    assign mid_calc  = (mid_sum > count_ext) ? count_reg : mid_sum[CNT_W-1:0];
    assign hi_calc   = (hi_sum > count_ext) ? count_reg : hi_sum[CNT_W-1:0];

    // --- ratio compare: ratio(j) < ratio(i) iff wj*ti < wi*tj ---
    assign wi     = rd_a_reg.wins[CMP_W-1:0];
    assign wj     = rd_b_reg.wins[CMP_W-1:0];
    assign ti     = {1'b0, wi} + {1'b0, rd_a_reg.losses[CMP_W-1:0]};
    assign tj     = {1'b0, wj} + {1'b0, rd_b_reg.losses[CMP_W-1:0]};
    // no games played counts as 0/1
    assign wi_eff = (ti == '0) ? '0 : wi;
    assign wj_eff = (tj == '0) ? '0 : wj;
    assign ti_eff = (ti == '0) ? (CMP_W+1)'(1) : ti;
    assign tj_eff = (tj == '0) ? (CMP_W+1)'(1) : tj;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_lhs_reg <= PROD_W'(wj_eff) * PROD_W'(ti_eff);
            prod_rhs_reg <= PROD_W'(wi_eff) * PROD_W'(tj_eff);
        end
    end

    // left run wins ties, which keeps the sort stable
    assign less   = prod_lhs_reg < prod_rhs_reg;
    assign take_j = (j_reg < hi_reg) && ((i_reg >= mid_reg) || less);
    assign wr_rec = take_j ? rd_b_reg : rd_a_reg;

    // --- control registers ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            width_reg     <= SUM_W'(1);
            lo_reg        <= '0;
            src_reg       <= 1'b0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                if (full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (s_tlast)
                begin
                    width_reg <= SUM_W'(1);
                    lo_reg    <= '0;
                    src_reg   <= 1'b0;
                end
            end
            if (cmd.pass_next)
            begin
                width_reg <= width_reg << 1;
                src_reg   <= !src_reg;
                lo_reg    <= '0;
            end
            if (cmd.blk_init)
            begin
                mid_reg <= mid_calc;
                hi_reg  <= hi_calc;
                i_reg   <= lo_reg[CNT_W-1:0];
                j_reg   <= mid_calc;
                k_reg   <= lo_reg[CNT_W-1:0];
            end
            if (cmd.blk_next)
            begin
                lo_reg <= hi_sum;
            end
            if (cmd.step)
            begin
                k_reg <= k_reg + CNT_W'(1);
                if (take_j)
                begin
                    j_reg <= j_reg + CNT_W'(1);
                end
                else
                begin
                    i_reg <= i_reg + CNT_W'(1);
                end
            end
            if (cmd.em_init)
            begin
                k_reg <= '0;
            end
            if (cmd.em_load)
            begin
                out_valid_reg <= 1'b1;
            end
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
                k_reg         <= k_reg + CNT_W'(1);
            end
            if (cmd.run_clear)
            begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end
        end
    end

    // --- output register ---
    always_ff @(posedge clk)
    begin
        if (cmd.em_load)
        begin
            out_rec_reg  <= rd_a_reg;
            out_last_reg <= ((k_reg + CNT_W'(1)) == count_reg);
            out_drop_reg <= overflow_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_rec_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_drop_reg;

    assign stat.last_acc  = acc && s_tlast;
    assign stat.pass_more = width_reg < count_ext;
    assign stat.blk_more  = lo_reg < count_ext;
    assign stat.mrg_more  = k_reg < hi_reg;
    assign stat.em_more   = k_reg < count_reg;
    assign stat.out_taken = out_valid_reg && m_tready;

endmodule

// ===== hw/rtl/win_ratio_merge_sorter.sv =====
// Top level of the win-ratio merge sorter: sequencer, datapath and checks.
//
// Takes team records (tag, wins, losses) one item per cycle into a 64-entry
// bank until an item with tlast, then runs a bottom-up merge sort, stable and
// ascending by win ratio wins/(wins+losses), compared exactly by
// cross-multiplying (no games played counts as ratio zero), and streams the
// records out in that order, tlast on the final one. Records arriving while
// 64 are held are discarded; tuser (dropped) is then high on every result of
// that run. Runs do not overlap: input is refused from the tlast item until
// the final result has been taken. A run of n records is loaded, then sorted
// in ceil(log2 n) merge passes, each record stepped through read, multiply
// and compare-and-write through one ratio comparator and two memory banks;
// each result is then read and registered, and the next is not read until
// the sink has taken it. There is no clearing pass after reset.
module win_ratio_merge_sorter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // team_tag[15:0], wins[31:16], losses[47:32]
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // sorted_tag[15:0], sorted_wins[31:16],
                                   // sorted_losses[47:32]
    output logic        m_tlast,   // last_out
    output logic        m_tuser    // dropped
);
    import wrms_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    wrms_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    wrms_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    assign s_tready = cmd.load_rdy;

    // loading and emitting never overlap
    a_load_emit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // after the final result of a run the block is loading again
    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |-> ##2 s_tready)
        else $error("block did not return to loading after run");

    // a tlast item ends loading: no more input is accepted after it
    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still accepted after end of run");

endmodule
